[src/wpe_pkg.sv]
// ----------------------------------------------------------------------------
// wpe_pkg
// Types, codes and helpers shared by the one-wire pixel waveform encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wpe_pkg;

  localparam int unsigned ColourW  = 8;
  localparam int unsigned WordW    = 3 * ColourW;
  localparam int unsigned BitCntW  = 5;
  localparam int unsigned CountW   = 16;
  localparam int unsigned BitTickW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [BitCntW-1:0] BitsPerPixel = BitCntW'(WordW);

  // item commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RESET     = 3'd4;

  // register reset values
  localparam logic [BitTickW-1:0] ONE_HIGH_RST  = 8'd35;
  localparam logic [BitTickW-1:0] ONE_LOW_RST   = 8'd28;
  localparam logic [BitTickW-1:0] ZERO_HIGH_RST = 8'd18;
  localparam logic [BitTickW-1:0] ZERO_LOW_RST  = 8'd45;
  localparam logic [CountW-1:0]   RESET_RST     = 16'd4000;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_HIGH  = 4'b0010,
    PH_LOW   = 4'b0100,
    PH_LATCH = 4'b1000
  } phase_e;

  typedef struct packed {
    logic               cmd;
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
    logic               last_pixel;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic accepted;
    logic frame_done;
    logic underrun;
  } result_t;

  // a tick count written as zero behaves as one
  function automatic logic [CountW-1:0] at_least_one(input logic [CountW-1:0] v);
    return (v == '0) ? CountW'(1) : v;
  endfunction

endpackage

`default_nettype wire

[src/ws2812_pixel_waveform_encoder.sv]
// ----------------------------------------------------------------------------
// ws2812_pixel_waveform_encoder
// One-wire serial LED pixel encoder: turns pixel and tick items into line
// levels, with per-bit high/low timing and a latch time at frame end.
// ----------------------------------------------------------------------------
// Takes one item per clock while not stalled: pixel items load a one-entry
// holding register, tick items advance the data line one time step and
// report its level. An item passes through an input register and then the
// line state update into a result register, which drives the outputs; the
// sustained rate is one item per cycle while the output is not stalled.
// Timing registers may be written only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module ws2812_pixel_waveform_encoder
  import wpe_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cmd_i,
  input  wire logic [ColourW-1:0]  red_i,
  input  wire logic [ColourW-1:0]  green_i,
  input  wire logic [ColourW-1:0]  blue_i,
  input  wire logic                last_pixel_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     line_level_o,
  output logic                     accepted_o,
  output logic                     frame_done_o,
  output logic                     underrun_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q;
  result_t res_d;
  logic    advance;

  // item moves into the result register when that is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= '{cmd: cmd_i, red: red_i, green: green_i, blue: blue_i,
                  last_pixel: last_pixel_i};
    end
  end

  wpe_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_en_i   (advance),
    .item_i      (item_q),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = res_q.line_level;
  assign accepted_o   = res_q.accepted;
  assign frame_done_o = res_q.frame_done;
  assign underrun_o   = res_q.underrun;

endmodule

`default_nettype wire

[src/wpe_core.sv]
// ----------------------------------------------------------------------------
// wpe_core
// Line state, holding register and timing registers; one item per enabled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpe_core
  import wpe_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                item_en_i,
  input  wire item_t               item_i,
  output result_t                  result_o
);

  logic [BitTickW-1:0] one_high_q, one_low_q, zero_high_q, zero_low_q;
  logic [CountW-1:0]   reset_ticks_q;

  logic [WordW-1:0]   shift_q, shift_d;
  logic [BitCntW-1:0] bits_q, bits_d;
  phase_e             phase_q, phase_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [WordW-1:0]   hold_word_q, hold_word_d;
  logic               hold_valid_q, hold_valid_d;
  logic               hold_last_q, hold_last_d;
  logic               cur_last_q, cur_last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_high_q    <= ONE_HIGH_RST;
      one_low_q     <= ONE_LOW_RST;
      zero_high_q   <= ZERO_HIGH_RST;
      zero_low_q    <= ZERO_LOW_RST;
      reset_ticks_q <= RESET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ONE_HIGH:  one_high_q    <= cfg_data_i[BitTickW-1:0];
        REG_ONE_LOW:   one_low_q     <= cfg_data_i[BitTickW-1:0];
        REG_ZERO_HIGH: zero_high_q   <= cfg_data_i[BitTickW-1:0];
        REG_ZERO_LOW:  zero_low_q    <= cfg_data_i[BitTickW-1:0];
        REG_RESET:     reset_ticks_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    shift_d      = shift_q;
    bits_d       = bits_q;
    phase_d      = phase_q;
    count_d      = count_q;
    hold_word_d  = hold_word_q;
    hold_valid_d = hold_valid_q;
    hold_last_d  = hold_last_q;
    cur_last_d   = cur_last_q;
    result_o     = '0;

    if (item_i.cmd == CMD_PIXEL) begin
      if (!hold_valid_q) begin
        hold_word_d  = {item_i.green, item_i.red, item_i.blue};
        hold_last_d  = item_i.last_pixel;
        hold_valid_d = 1'b1;
        result_o.accepted = 1'b1;
      end
      result_o.line_level = (phase_q == PH_HIGH);
    end else begin
      // idle with a pixel waiting: load it and start its first bit at once
      if (phase_q == PH_IDLE && hold_valid_q) begin
        shift_d      = hold_word_q;
        cur_last_d   = hold_last_q;
        hold_valid_d = 1'b0;
        bits_d       = BitsPerPixel;
        phase_d      = PH_HIGH;
        count_d      = at_least_one(CountW'(hold_word_q[WordW-1] ? one_high_q : zero_high_q));
      end

      result_o.line_level = (phase_d == PH_HIGH);

      if (phase_d != PH_IDLE) begin
        count_d = count_d - CountW'(1);
        if (count_d == '0) begin
          unique case (phase_d)
            PH_HIGH: begin
              phase_d = PH_LOW;
              count_d = at_least_one(CountW'(shift_d[WordW-1] ? one_low_q : zero_low_q));
            end
            PH_LOW: begin
              shift_d = {shift_d[WordW-2:0], 1'b0};
              bits_d  = (bits_d == '0) ? '0 : bits_d - BitCntW'(1);
              if (bits_d != '0) begin
                phase_d = PH_HIGH;
                count_d = at_least_one(CountW'(shift_d[WordW-1] ? one_high_q : zero_high_q));
              end else if (cur_last_d) begin
                phase_d = PH_LATCH;
                count_d = at_least_one(reset_ticks_q);
              end else begin
                phase_d = PH_IDLE;
                result_o.underrun = !hold_valid_d;
              end
            end
            PH_LATCH: begin
              phase_d = PH_IDLE;
              result_o.frame_done = 1'b1;
            end
            default: phase_d = PH_IDLE;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q      <= '0;
      bits_q       <= '0;
      phase_q      <= PH_IDLE;
      count_q      <= '0;
      hold_word_q  <= '0;
      hold_valid_q <= 1'b0;
      hold_last_q  <= 1'b0;
      cur_last_q   <= 1'b0;
    end else if (item_en_i) begin
      shift_q      <= shift_d;
      bits_q       <= bits_d;
      phase_q      <= phase_d;
      count_q      <= count_d;
      hold_word_q  <= hold_word_d;
      hold_valid_q <= hold_valid_d;
      hold_last_q  <= hold_last_d;
      cur_last_q   <= cur_last_d;
    end
  end

endmodule

`default_nettype wire

[src/wpe_checker.sv]
// ----------------------------------------------------------------------------
// wpe_checker
// Port-level checks for the pixel waveform encoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wpe_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic line_level_o,
  input wire logic accepted_o,
  input wire logic frame_done_o,
  input wire logic underrun_o
);

  // a stalled result holds until its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_level_o) &&
      $stable(accepted_o) && $stable(frame_done_o) && $stable(underrun_o))
    else $error("stalled result changed");

  // the input side is never stalled while nothing is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty result register");

  // a pixel result never carries tick flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> !frame_done_o && !underrun_o)
    else $error("accepted pixel result carries tick flags");

  // frame end and underrun both fall on a low tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_done_o || underrun_o) |-> !line_level_o &&
      !(frame_done_o && underrun_o))
    else $error("frame end or underrun on a high tick");

endmodule

bind ws2812_pixel_waveform_encoder wpe_checker u_wpe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .line_level_o (line_level_o),
  .accepted_o   (accepted_o),
  .frame_done_o (frame_done_o),
  .underrun_o   (underrun_o)
);

`default_nettype wire
